// ----- rtl/lcp_pkg.sv -----
package lcp_pkg;

    localparam int unsigned LINE_BUFFER_BYTES_DEFAULT = 48;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_BS  = 8'h08;
    localparam logic [7:0] CHAR_DEL = 8'h7F;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    localparam logic [3:0] CMD_NONE    = 4'd0;
    localparam logic [3:0] CMD_STOP    = 4'd1;
    localparam logic [3:0] CMD_GRAB    = 4'd2;
    localparam logic [3:0] CMD_GRABPID = 4'd3;
    localparam logic [3:0] CMD_LIGHT   = 4'd4;
    localparam logic [3:0] CMD_HARD    = 4'd5;
    localparam logic [3:0] CMD_UNEVEN  = 4'd6;
    localparam logic [3:0] CMD_YEAH    = 4'd7;
    localparam logic [3:0] CMD_RELEASE = 4'd8;
    localparam logic [3:0] CMD_SETUP   = 4'd9;
    localparam logic [3:0] CMD_ADJUST  = 4'd10;

    localparam int unsigned NUM_KW = 10;
    localparam int unsigned KW_MAX = 7;

    typedef enum logic [1:0] {
        OP_STORE,
        OP_ERASE,
        OP_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } entry_t;

    typedef struct packed {
        logic [3:0]  command_code;
        logic [7:0]  motor_index;
        logic        direction_negative;
        logic [31:0] rotation_micro_units;
    } result_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned i);
        logic [8*KW_MAX-1:0] s;
        case (k)
            0:       s = {"stop", 24'h0};
            1:       s = {"grab", 24'h0};
            2:       s = "grabpid";
            3:       s = {"light", 16'h0};
            4:       s = {"hard", 24'h0};
            5:       s = {"uneven", 8'h0};
            6:       s = {"yeah", 24'h0};
            7:       s = "release";
            8:       s = {"relase", 8'h0};
            default: s = {"setup", 16'h0};
        endcase
        return s[8*(KW_MAX-1-i) +: 8];
    endfunction

    function automatic logic [2:0] kw_len(input int unsigned k);
        case (k)
            0, 1, 4, 6: return 3'd4;
            2, 7:       return 3'd7;
            3, 9:       return 3'd5;
            default:    return 3'd6;
        endcase
    endfunction

    function automatic logic [3:0] kw_code(input int unsigned k);
        case (k)
            0:       return CMD_STOP;
            1:       return CMD_GRAB;
            2:       return CMD_GRABPID;
            3:       return CMD_LIGHT;
            4:       return CMD_HARD;
            5:       return CMD_UNEVEN;
            6:       return CMD_YEAH;
            7, 8:    return CMD_RELEASE;
            default: return CMD_SETUP;
        endcase
    endfunction

endpackage

// ----- rtl/lcp_front.sv -----
module lcp_front (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    output logic                q_push,
    output lcp_pkg::entry_t     q_entry,
    input  logic                q_full
);

    always_comb begin
        s_ready        = !q_full;
        q_push         = s_valid && !q_full;
        q_entry.data   = s_rx_byte;
        if (s_rx_byte == lcp_pkg::CHAR_CR || s_rx_byte == lcp_pkg::CHAR_LF) begin
            q_entry.op = lcp_pkg::OP_END;
        end else if (s_rx_byte == lcp_pkg::CHAR_BS || s_rx_byte == lcp_pkg::CHAR_DEL) begin
            q_entry.op = lcp_pkg::OP_ERASE;
        end else begin
            q_entry.op = lcp_pkg::OP_STORE;
        end
    end

endmodule

// ----- rtl/lcp_queue.sv -----
module lcp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lcp_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output lcp_pkg::entry_t head
);

    lcp_pkg::entry_t slot_reg [lcp_pkg::QUEUE_DEPTH];
    logic            rd_reg, wr_reg;
    logic [1:0]      count_reg;

    assign full      = count_reg == 2'(lcp_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != 2'd0;
    assign head      = slot_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_entry;
        end
        if (!aresetn) begin
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_reg <= !wr_reg;
            end
            if (pop) begin
                rd_reg <= !rd_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ----- rtl/lcp_back.sv -----
module lcp_back #(
    parameter int unsigned LINE_BUFFER_BYTES = lcp_pkg::LINE_BUFFER_BYTES_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  lcp_pkg::entry_t  q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output lcp_pkg::result_t m_result
);

    localparam int unsigned LW = $clog2(LINE_BUFFER_BYTES);
    localparam int unsigned AW = (LW < 1) ? 1 : LW;

    typedef enum logic [3:0] {
        S_IDLE, S_LEN, S_RD, S_KW, S_ADJ, S_MUL1, S_MUL2, S_FIN, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        P_LEAD, P_A, P_D, P_J, P_J2, P_MOTOR, P_MB, P_SIGNB, P_WHOLE, P_FRAC, P_TAIL, P_BAD
    } pstate_t;

    state_t     state_reg;
    pstate_t    ps_reg;
    logic [7:0] mem [LINE_BUFFER_BYTES];
    logic [7:0] rdata_reg;
    logic [LW:0] len_reg, eff_reg, idx_reg;
    logic [lcp_pkg::NUM_KW-1:0] kw_ok_reg;
    logic [11:0] motor_reg;
    logic        neg_reg, any_reg;
    logic [31:0] whole_reg, frac_reg, rot_reg;
    logic [19:0] scale_reg;
    logic [31:0] prod_reg;
    lcp_pkg::result_t res_reg;
    logic [7:0]  c, fc;
    logic [3:0]  dig;
    logic [3:0]  kcode;

    function automatic logic [19:0] next_scale(input logic [19:0] s);
        case (s)
            20'd100000: return 20'd10000;
            20'd10000:  return 20'd1000;
            20'd1000:   return 20'd100;
            20'd100:    return 20'd10;
            20'd10:     return 20'd1;
            default:    return 20'd0;
        endcase
    endfunction

    assign m_valid  = state_reg == S_OUT;
    assign m_result = res_reg;
    assign q_pop    = state_reg == S_IDLE && q_valid;
    assign c        = rdata_reg;
    assign fc       = lcp_pkg::fold(rdata_reg);
    assign dig      = rdata_reg[3:0];

    always_comb begin
        kcode = lcp_pkg::CMD_NONE;
        for (int k = lcp_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (kw_ok_reg[k] && eff_reg == (LW+1)'(lcp_pkg::kw_len(k))) begin
                kcode = lcp_pkg::kw_code(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_head.op == lcp_pkg::OP_STORE
                && len_reg < (LW+1)'(LINE_BUFFER_BYTES - 1)) begin
            mem[len_reg[AW-1:0]] <= q_head.data;
        end
        rdata_reg <= mem[idx_reg[AW-1:0]];
        if (!aresetn) begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        unique case (q_head.op)
                            lcp_pkg::OP_ERASE: begin
                                if (len_reg != '0) begin
                                    len_reg <= len_reg - 1'b1;
                                end
                            end
                            lcp_pkg::OP_STORE: begin
                                if (len_reg < (LW+1)'(LINE_BUFFER_BYTES - 1)) begin
                                    len_reg <= len_reg + 1'b1;
                                end else begin
                                    len_reg <= '0;
                                end
                            end
                            default: begin
                                state_reg <= S_LEN;
                                eff_reg   <= '0;
                                idx_reg   <= '0;
                            end
                        endcase
                    end
                end
                S_LEN: begin
                    state_reg <= S_RD;
                end
                S_RD: begin
                    if (eff_reg < len_reg && c != 8'h00) begin
                        eff_reg   <= eff_reg + 1'b1;
                        idx_reg   <= eff_reg + 1'b1;
                        state_reg <= S_LEN;
                    end else begin
                        len_reg   <= '0;
                        idx_reg   <= '0;
                        kw_ok_reg <= '1;
                        state_reg <= S_KW;
                    end
                end
                S_KW: begin
                    // Reads are registered; idx 0 data arrives next cycle.
                    state_reg <= S_ADJ;
                    ps_reg    <= P_LEAD;
                    motor_reg <= '0;
                    whole_reg <= '0;
                    frac_reg  <= '0;
                    scale_reg <= 20'd100000;
                    any_reg   <= 1'b0;
                    neg_reg   <= 1'b0;
                    idx_reg   <= idx_reg + 1'b1;
                end
                S_ADJ: begin
                    logic       at_end;
                    logic [LW:0] pos;
                    pos    = idx_reg - 1'b1;
                    at_end = pos >= eff_reg;
                    for (int k = 0; k < lcp_pkg::NUM_KW; k++) begin
                        if (pos < (LW+1)'(lcp_pkg::KW_MAX) && !at_end
                                && fc != lcp_pkg::kw_char(k, pos[2:0])) begin
                            kw_ok_reg[k] <= 1'b0;
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                    unique case (ps_reg)
                        P_LEAD: if (at_end) ps_reg <= P_BAD;
                                else if (fc == "a") ps_reg <= P_D;
                                else if (!lcp_pkg::is_blank(c)) ps_reg <= P_BAD;
                        P_D:    ps_reg <= (!at_end && fc == "d") ? P_J : P_BAD;
                        P_J:    ps_reg <= (!at_end && fc == "j") ? P_J2 : P_BAD;
                        P_J2:   ps_reg <= (!at_end && lcp_pkg::is_blank(c)) ? P_A : P_BAD;
                        P_A: begin
                            if (at_end) ps_reg <= P_BAD;
                            else if (lcp_pkg::is_digit(c)) begin
                                motor_reg <= 12'(motor_reg * 4'd10 + dig);
                                any_reg   <= 1'b1;
                                ps_reg    <= P_MOTOR;
                            end else if (!lcp_pkg::is_blank(c)) ps_reg <= P_BAD;
                        end
                        P_MOTOR: begin
                            if (!at_end && lcp_pkg::is_digit(c)) begin
                                if (motor_reg <= 12'd255) begin
                                    motor_reg <= 12'(motor_reg * 4'd10 + dig);
                                end
                            end else if (!at_end && c == "+") begin
                                any_reg <= 1'b0;
                                ps_reg  <= P_SIGNB;
                            end else if (!at_end && c == "-") begin
                                neg_reg <= 1'b1;
                                any_reg <= 1'b0;
                                ps_reg  <= P_SIGNB;
                            end else if (!at_end && lcp_pkg::is_blank(c)) begin
                                ps_reg <= P_MB;
                            end else ps_reg <= P_BAD;
                        end
                        P_MB: begin
                            if (!at_end && c == "+") ps_reg <= P_SIGNB;
                            else if (!at_end && c == "-") begin
                                neg_reg <= 1'b1;
                                ps_reg  <= P_SIGNB;
                            end else if (at_end || !lcp_pkg::is_blank(c)) ps_reg <= P_BAD;
                            any_reg <= 1'b0;
                        end
                        P_SIGNB: begin
                            if (at_end) ps_reg <= P_BAD;
                            else if (lcp_pkg::is_digit(c)) begin
                                whole_reg <= 32'(whole_reg * 4'd10) + 32'(dig);
                                any_reg   <= 1'b1;
                                ps_reg    <= P_WHOLE;
                            end else if (c == ".") ps_reg <= P_FRAC;
                            else if (!lcp_pkg::is_blank(c)) ps_reg <= P_BAD;
                        end
                        P_WHOLE: begin
                            if (at_end) ;
                            else if (lcp_pkg::is_digit(c)) begin
                                whole_reg <= 32'(whole_reg * 4'd10) + 32'(dig);
                            end else if (c == ".") ps_reg <= P_FRAC;
                            else if (lcp_pkg::is_blank(c)) ps_reg <= P_TAIL;
                            else ps_reg <= P_BAD;
                        end
                        P_FRAC: begin
                            if (at_end) ;
                            else if (lcp_pkg::is_digit(c)) begin
                                any_reg <= 1'b1;
                                if (scale_reg != '0) begin
                                    frac_reg  <= frac_reg + 32'(20'(dig * scale_reg));
                                    scale_reg <= next_scale(scale_reg);
                                end
                            end else if (lcp_pkg::is_blank(c)) ps_reg <= P_TAIL;
                            else ps_reg <= P_BAD;
                        end
                        P_TAIL: if (!at_end && !lcp_pkg::is_blank(c)) ps_reg <= P_BAD;
                        default: ;
                    endcase
                    if (at_end) begin
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    prod_reg  <= 32'(whole_reg * 32'd1000000);
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    rot_reg   <= prod_reg + frac_reg;
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    lcp_pkg::result_t r;
                    r = '0;
                    if (kcode != lcp_pkg::CMD_NONE) begin
                        r.command_code = kcode;
                    end else if (any_reg && motor_reg <= 12'd255
                            && (ps_reg == P_WHOLE || ps_reg == P_FRAC || ps_reg == P_TAIL)) begin
                        r.command_code         = lcp_pkg::CMD_ADJUST;
                        r.motor_index          = motor_reg[7:0];
                        r.direction_negative   = neg_reg;
                        r.rotation_micro_units = rot_reg;
                    end
                    res_reg   <= r;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/line_command_parser.sv -----
// Channel | Ports                                   | Direction
// s_      | s_valid s_ready s_rx_byte               | in
// m_      | m_valid m_ready m_command_code ...      | out
// A stored or erased byte is handled in the back end's idle state; a line end
// occupies it while the line store is scanned up to the first zero through its
// single read port, then while the line is parsed and its result handed out.
// A two-entry queue lets the front keep taking bytes meanwhile.
// Reset is synchronous and active low; the line store itself is not cleared.
// The result holds on m_ until m_ready; the back end waits there.
module line_command_parser #(
    parameter int unsigned LINE_BUFFER_BYTES = lcp_pkg::LINE_BUFFER_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_command_code,
    output logic [7:0]  m_motor_index,
    output logic        m_direction_negative,
    output logic [31:0] m_rotation_micro_units
);

    logic             q_push, q_full, q_pop, q_valid;
    lcp_pkg::entry_t  q_in, q_head;
    lcp_pkg::result_t res;

    lcp_front u_front (
        .s_valid, .s_ready, .s_rx_byte,
        .q_push, .q_entry(q_in), .q_full
    );

    lcp_queue u_queue (
        .aclk, .aresetn, .push(q_push), .push_entry(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_valid), .head(q_head)
    );

    lcp_back #(.LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)) u_back (
        .aclk, .aresetn, .q_valid, .q_head, .q_pop,
        .m_valid, .m_ready, .m_result(res)
    );

    assign m_command_code         = res.command_code;
    assign m_motor_index          = res.motor_index;
    assign m_direction_negative   = res.direction_negative;
    assign m_rotation_micro_units = res.rotation_micro_units;

endmodule

// ----- rtl/lcp_checker.sv -----
module lcp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_command_code,
    input logic [7:0]  m_motor_index,
    input logic        m_direction_negative,
    input logic [31:0] m_rotation_micro_units
);

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_command_code <= lcp_pkg::CMD_ADJUST) else $error("bad code");

    a_non_adjust_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_command_code != lcp_pkg::CMD_ADJUST |->
        m_motor_index == 8'd0 && !m_direction_negative && m_rotation_micro_units == 32'd0)
        else $error("non-adjust payload not zero");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_command_code)
        && $stable(m_motor_index) && $stable(m_direction_negative)
        && $stable(m_rotation_micro_units))
        else $error("result dropped");

    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid) else $error("repeated result");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid) else $error("input transaction withdrawn");

endmodule

bind line_command_parser lcp_checker u_lcp_checker (.*);
